>>> rtl/splb_pkg.sv
// Shared constants, codes and control types of the sorted price-level book.
// No dependencies; every other file of the block imports this package.
package splb_pkg;

    // Book geometry and field widths
    localparam int BOOK_DEPTH = 64;
    localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);
    localparam int PRICE_W    = 64;
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int LEVELS_W   = 7;
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 208;
    localparam int OUT_USER_W = 3;

    // Side update operations
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE   = 2'd0;
    localparam t_op OP_UPDATE = 2'd1;
    localparam t_op OP_INSERT = 2'd2;
    localparam t_op OP_ERASE  = 2'd3;

    // Result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_UPDATED  = 3'd0;
    localparam t_status ST_INSERTED = 3'd1;
    localparam t_status ST_ERASED   = 3'd2;
    localparam t_status ST_MISSED   = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // Controller -> datapath
    typedef struct packed {
        logic    cap;       // capture key and compare vectors
        t_op     op;        // operation for the keyed side
        t_status status;    // status of the result being loaded
        logic    out_load;  // load output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic hit;        // price present on keyed side
        logic full;       // keyed side holds BOOK_DEPTH levels
        logic size_zero;  // update size is zero (erase request)
    } t_stat;

endpackage

>>> rtl/splb_side.sv
// One side of the book: a row of sorted price/size cells with parallel
// compare and shift-insert/shift-erase. Depends on splb_pkg.
module splb_side (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_ascending,
    input  logic                             i_cap,
    input  logic signed [splb_pkg::PRICE_W-1:0] i_price,
    input  splb_pkg::t_op                    i_op,
    input  logic signed [splb_pkg::PRICE_W-1:0] i_key_price,
    input  logic signed [splb_pkg::SIZE_W-1:0]  i_key_size,
    output logic                             o_hit,
    output logic                             o_full,
    output logic                             o_n_valid,
    output logic signed [splb_pkg::PRICE_W-1:0] o_n_price,
    output logic signed [splb_pkg::SIZE_W-1:0]  o_n_size,
    output logic [splb_pkg::CNT_W-1:0]       o_n_count
);
    import splb_pkg::*;

    logic signed [PRICE_W-1:0] r_price [BOOK_DEPTH];
    logic signed [PRICE_W-1:0] n_price [BOOK_DEPTH];
    logic signed [SIZE_W-1:0]  r_size  [BOOK_DEPTH];
    logic signed [SIZE_W-1:0]  n_size  [BOOK_DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [BOOK_DEPTH-1:0]     r_match;
    logic [BOOK_DEPTH-1:0]     r_ge;
    logic [BOOK_DEPTH-1:0]     c_match;
    logic [BOOK_DEPTH-1:0]     c_ge;
    logic [BOOK_DEPTH-1:0]     cell_valid;
    logic [BOOK_DEPTH-1:0]     ins_ge;

    // Occupancy of each cell
    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            cell_valid[i] = CNT_W'(i) < r_count;
        end
    end

    // Parallel compare of the incoming price against every held level
    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            c_match[i] = cell_valid[i] && (r_price[i] == i_price);
            c_ge[i]    = cell_valid[i] && ((r_price[i] == i_price) ||
                         (i_ascending ? (i_price < r_price[i]) : (i_price > r_price[i])));
        end
    end

    // Cells at or behind the insert point (empty cells count as behind)
    always_comb begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            ins_ge[i] = r_ge[i] || !cell_valid[i];
        end
    end

    assign o_hit  = |r_match;
    assign o_full = r_count == CNT_W'(BOOK_DEPTH);

    // Cell update: each cell looks only at itself and its neighbors
    always_comb begin
        int prv;
        int nxt;
        n_count = r_count;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            n_price[i] = r_price[i];
            n_size[i]  = r_size[i];
        end
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            prv = (i == 0) ? 0 : i - 1;
            nxt = (i == BOOK_DEPTH - 1) ? i : i + 1;
            case (i_op)
                OP_UPDATE: begin
                    if (r_match[i]) begin
                        n_size[i] = i_key_size;
                    end
                end
                OP_INSERT: begin
                    if (ins_ge[i]) begin
                        if (i != 0 && ins_ge[prv]) begin
                            n_price[i] = r_price[prv];
                            n_size[i]  = r_size[prv];
                        end else begin
                            n_price[i] = i_key_price;
                            n_size[i]  = i_key_size;
                        end
                    end
                end
                OP_ERASE: begin
                    if (r_ge[i]) begin
                        n_price[i] = r_price[nxt];
                        n_size[i]  = r_size[nxt];
                    end
                end
                default: begin
                end
            endcase
        end
        case (i_op)
            OP_INSERT: n_count = r_count + 1'b1;
            OP_ERASE:  n_count = r_count - 1'b1;
            default:   n_count = r_count;
        endcase
    end

    // Best level after this update
    assign o_n_valid = n_count != '0;
    assign o_n_price = o_n_valid ? n_price[0] : '0;
    assign o_n_size  = o_n_valid ? n_size[0] : '0;
    assign o_n_count = n_count;

    // Level count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cells and captured compare vectors
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            r_price[i] <= n_price[i];
            r_size[i]  <= n_size[i];
        end
        if (i_cap) begin
            r_match <= c_match;
            r_ge    <= c_ge;
        end
    end

endmodule

>>> rtl/splb_dp.sv
// Datapath: key capture, the bid and ask cell rows and the output register.
// Depends on splb_pkg and splb_side.
module splb_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [splb_pkg::IN_DATA_W-1:0]     i_data,
    input  logic [splb_pkg::IN_USER_W-1:0]     i_user,
    input  splb_pkg::t_cmd                     i_cmd,
    output splb_pkg::t_stat                    o_stat,
    output logic [splb_pkg::OUT_DATA_W-1:0]    o_data,
    output logic [splb_pkg::OUT_USER_W-1:0]    o_user
);
    import splb_pkg::*;

    logic                      r_key_ask;
    logic signed [PRICE_W-1:0] r_key_price;
    logic signed [SIZE_W-1:0]  r_key_size;
    logic signed [PRICE_W-1:0] in_price;
    t_op                       bid_op;
    t_op                       ask_op;
    logic                      bid_hit, bid_full, bid_valid;
    logic                      ask_hit, ask_full, ask_valid;
    logic signed [PRICE_W-1:0] bid_price, ask_price;
    logic signed [SIZE_W-1:0]  bid_size, ask_size;
    logic [CNT_W-1:0]          bid_count, ask_count;
    logic [OUT_DATA_W-1:0]     r_out_data;
    t_status                   r_out_status;

    assign in_price = i_data[PRICE_W-1:0];

    // Key capture on an accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_key_ask   <= i_user[0];
            r_key_price <= i_data[PRICE_W-1:0];
            r_key_size  <= i_data[PRICE_W+SIZE_W-1:PRICE_W];
        end
    end

    // Steer the operation to the keyed side
    assign bid_op = r_key_ask ? OP_NONE : i_cmd.op;
    assign ask_op = r_key_ask ? i_cmd.op : OP_NONE;

    splb_side u_bid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ascending (1'b0),
        .i_cap       (i_cmd.cap && !i_user[0]),
        .i_price     (in_price),
        .i_op        (bid_op),
        .i_key_price (r_key_price),
        .i_key_size  (r_key_size),
        .o_hit       (bid_hit),
        .o_full      (bid_full),
        .o_n_valid   (bid_valid),
        .o_n_price   (bid_price),
        .o_n_size    (bid_size),
        .o_n_count   (bid_count)
    );

    splb_side u_ask (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ascending (1'b1),
        .i_cap       (i_cmd.cap && i_user[0]),
        .i_price     (in_price),
        .i_op        (ask_op),
        .i_key_price (r_key_price),
        .i_key_size  (r_key_size),
        .o_hit       (ask_hit),
        .o_full      (ask_full),
        .o_n_valid   (ask_valid),
        .o_n_price   (ask_price),
        .o_n_size    (ask_size),
        .o_n_count   (ask_count)
    );

    // Status of the keyed side
    assign o_stat.hit       = r_key_ask ? ask_hit : bid_hit;
    assign o_stat.full      = r_key_ask ? ask_full : bid_full;
    assign o_stat.size_zero = r_key_size == '0;

    // Output register, loaded with the book state after the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_data   <= {LEVELS_W'(ask_count), LEVELS_W'(bid_count),
                             ask_size, ask_price, ask_valid,
                             bid_size, bid_price, bid_valid};
        end
    end

    assign o_data = r_out_data;
    assign o_user = r_out_status;

endmodule

>>> rtl/splb_ctrl.sv
// Controller: accept/apply sequencing, status decision and output valid.
// Depends on splb_pkg.
module splb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  splb_pkg::t_stat i_stat,
    output splb_pkg::t_cmd  o_cmd
);
    import splb_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic    r_state;
    logic    n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    go;
    t_op     dec_op;
    t_status dec_status;

    // Decide the operation and status from the captured compares
    always_comb begin
        if (i_stat.size_zero) begin
            dec_op     = i_stat.hit ? OP_ERASE : OP_NONE;
            dec_status = i_stat.hit ? ST_ERASED : ST_MISSED;
        end else if (i_stat.hit) begin
            dec_op     = OP_UPDATE;
            dec_status = ST_UPDATED;
        end else if (i_stat.full) begin
            dec_op     = OP_NONE;
            dec_status = ST_FULL;
        end else begin
            dec_op     = OP_INSERT;
            dec_status = ST_INSERTED;
        end
    end

    // Apply only when the output register is free
    assign go = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);

    assign o_in_ready   = r_state == S_IDLE;
    assign o_cmd.cap    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.op     = go ? dec_op : OP_NONE;
    assign o_cmd.status = dec_status;
    assign o_cmd.out_load = go;
    assign o_out_valid  = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output beat pending
    always_comb begin
        if (go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/sorted_price_level_book_unit.sv
// Top level of the sorted price-level book: controller plus datapath.
// Depends on splb_pkg, splb_ctrl, splb_dp (and splb_side below it).
//
//  Channel  | Dir | tdata (low bit up)                               | tuser
//  ---------+-----+--------------------------------------------------+-------------
//  s_axis   | in  | level_price[63:0], level_size[95:64]             | side[0]
//  m_axis   | out | bid valid/price/size, ask valid/price/size,      | status[2:0]
//           |     | bid_levels, ask_levels                           |
//
// Each update has an accept cycle, which compares the price against every
// level of the chosen side in parallel, and an apply cycle, which shifts the
// cell row and loads the output register. A new beat is accepted after the apply.
// The apply cycle waits while a previous result is still held on m_axis.
// Reset is synchronous, active low; it clears the level counts and control state.
module sorted_price_level_book_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // level_price[63:0], level_size[95:64]
    input  logic [splb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // side[0]
    input  logic [splb_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // best_bid_valid[0], best_bid_price[64:1], best_bid_size[96:65],
    // best_ask_valid[97], best_ask_price[161:98], best_ask_size[193:162],
    // bid_levels[200:194], ask_levels[207:201]
    output logic [splb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[2:0]
    output logic [splb_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import splb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    splb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    splb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

endmodule

>>> tb/book_checker.sv
`timescale 1ns / 100ps
// Checker of the sorted price-level book: watches both stream channels, predicts
// each result from its own copy of the two level tables, compares every field.
// Depends on splb_pkg only.
module book_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    // level_price[63:0], level_size[95:64]
    input  logic [splb_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // side[0]
    input  logic [splb_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // best_bid_valid[0], best_bid_price[64:1], best_bid_size[96:65],
    // best_ask_valid[97], best_ask_price[161:98], best_ask_size[193:162],
    // bid_levels[200:194], ask_levels[207:201]
    input  logic [splb_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // status[2:0]
    input  logic [splb_pkg::OUT_USER_W-1:0] i_m_axis_tuser,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_peak_bid,
    output int                             o_peak_ask,
    output logic [4:0]                     o_status_seen
);
    import splb_pkg::*;

    localparam int REPORT_MAX = 10;

    // One result beat: status plus top of book and level counts
    typedef struct packed {
        t_status              status;
        logic                 bid_ok;
        logic [PRICE_W-1:0]   bid_px;
        logic [SIZE_W-1:0]    bid_sz;
        logic                 ask_ok;
        logic [PRICE_W-1:0]   ask_px;
        logic [SIZE_W-1:0]    ask_sz;
        logic [LEVELS_W-1:0]  bid_lv;
        logic [LEVELS_W-1:0]  ask_lv;
    } t_book_view;

    // Level tables, index 0 = bid side (high to low), 1 = ask side (low to high)
    logic signed [PRICE_W-1:0] level_px [2][BOOK_DEPTH];
    logic signed [SIZE_W-1:0]  level_sz [2][BOOK_DEPTH];
    int                        level_cnt [2];

    t_book_view view_q [$];
    t_book_view want, got;
    string      diffs;
    int         fails, results;

    // Apply one update to the tables and return the view it should produce
    task automatic apply_update(input logic ask, input logic signed [PRICE_W-1:0] px,
                                input logic signed [SIZE_W-1:0] qty,
                                output t_book_view v);
        int      n, hit, pos, i;
        t_status st;
        begin
            n   = level_cnt[ask];
            hit = -1;
            pos = n;
            for (i = 0; i < n; i++)
                if (hit < 0 && level_px[ask][i] == px) hit = i;
            if (qty == 0) begin
                if (hit < 0) begin
                    st = ST_MISSED;
                end else begin
                    for (i = hit; i < n - 1; i++) begin
                        level_px[ask][i] = level_px[ask][i+1];
                        level_sz[ask][i] = level_sz[ask][i+1];
                    end
                    level_cnt[ask] = n - 1;
                    st = ST_ERASED;
                end
            end else if (hit >= 0) begin
                level_sz[ask][hit] = qty;
                st = ST_UPDATED;
            end else if (n >= BOOK_DEPTH) begin
                st = ST_FULL;
            end else begin
                // backward scan leaves pos at the first level the new price beats
                for (i = n - 1; i >= 0; i--)
                    if (ask ? (px < level_px[ask][i]) : (px > level_px[ask][i])) pos = i;
                for (i = n; i > pos; i--) begin
                    level_px[ask][i] = level_px[ask][i-1];
                    level_sz[ask][i] = level_sz[ask][i-1];
                end
                level_px[ask][pos] = px;
                level_sz[ask][pos] = qty;
                level_cnt[ask] = n + 1;
                st = ST_INSERTED;
            end
            v.status = st;
            v.bid_ok = (level_cnt[0] > 0);
            v.bid_px = v.bid_ok ? level_px[0][0] : '0;
            v.bid_sz = v.bid_ok ? level_sz[0][0] : '0;
            v.ask_ok = (level_cnt[1] > 0);
            v.ask_px = v.ask_ok ? level_px[1][0] : '0;
            v.ask_sz = v.ask_ok ? level_sz[1][0] : '0;
            v.bid_lv = LEVELS_W'(level_cnt[0]);
            v.ask_lv = LEVELS_W'(level_cnt[1]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level_cnt[0] = 0;
            level_cnt[1] = 0;
            view_q.delete();
            fails   = 0;
            results = 0;
            o_peak_bid    <= 0;
            o_peak_ask    <= 0;
            o_status_seen <= '0;
        end else begin
            // input beat: predict its result
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_update(i_s_axis_tuser[0], i_s_axis_tdata[PRICE_W-1:0],
                             i_s_axis_tdata[PRICE_W +: SIZE_W], want);
                view_q.push_back(want);
                o_status_seen[want.status] <= 1'b1;
                if (level_cnt[0] > o_peak_bid) o_peak_bid <= level_cnt[0];
                if (level_cnt[1] > o_peak_ask) o_peak_ask <= level_cnt[1];
            end
            // output beat: compare with the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                results++;
                got.status = i_m_axis_tuser;
                got.bid_ok = i_m_axis_tdata[0];
                got.bid_px = i_m_axis_tdata[64:1];
                got.bid_sz = i_m_axis_tdata[96:65];
                got.ask_ok = i_m_axis_tdata[97];
                got.ask_px = i_m_axis_tdata[161:98];
                got.ask_sz = i_m_axis_tdata[193:162];
                got.bid_lv = i_m_axis_tdata[200:194];
                got.ask_lv = i_m_axis_tdata[207:201];
                if (view_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("%0t: result beat with no update pending", $time);
                end else begin
                    want  = view_q.pop_front();
                    diffs = "";
                    if (got.status !== want.status) diffs = {diffs, " status"};
                    if (got.bid_ok !== want.bid_ok) diffs = {diffs, " bid_valid"};
                    if (got.bid_px !== want.bid_px) diffs = {diffs, " bid_price"};
                    if (got.bid_sz !== want.bid_sz) diffs = {diffs, " bid_size"};
                    if (got.ask_ok !== want.ask_ok) diffs = {diffs, " ask_valid"};
                    if (got.ask_px !== want.ask_px) diffs = {diffs, " ask_price"};
                    if (got.ask_sz !== want.ask_sz) diffs = {diffs, " ask_size"};
                    if (got.bid_lv !== want.bid_lv) diffs = {diffs, " bid_levels"};
                    if (got.ask_lv !== want.ask_lv) diffs = {diffs, " ask_levels"};
                    if (diffs != "") begin
                        fails++;
                        if (fails <= REPORT_MAX) begin
                            $display("%0t: result %0d differs in%s", $time, results, diffs);
                            $display("  exp st=%0d bid %b %h %h ask %b %h %h lv %0d/%0d",
                                     want.status, want.bid_ok, want.bid_px, want.bid_sz,
                                     want.ask_ok, want.ask_px, want.ask_sz,
                                     want.bid_lv, want.ask_lv);
                            $display("  got st=%0d bid %b %h %h ask %b %h %h lv %0d/%0d",
                                     got.status, got.bid_ok, got.bid_px, got.bid_sz,
                                     got.ask_ok, got.ask_px, got.ask_sz,
                                     got.bid_lv, got.ask_lv);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_results    <= results;
        o_pending    <= view_q.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the price-level book testbench: clock, reset, stream stimulus and verdict.
// Depends on splb_pkg, sorted_price_level_book_unit and book_checker.
module testbench;
    import splb_pkg::*;

    localparam real CLK_PERIOD = 4.0;
    localparam int  HOLD_LEN   = 300;
    localparam int  PX_POOL    = 80;
    localparam int  TAIL       = 20;
    localparam logic SIDE_BID  = 1'b0;
    localparam logic SIDE_ASK  = 1'b1;
    localparam logic [PRICE_W-1:0] PX_MIN = 64'h8000_0000_0000_0000;
    localparam logic [PRICE_W-1:0] PX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // level_price[63:0], level_size[95:64]
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // side[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // bid v/p/s, ask v/p/s, bid/ask levels
    logic [OUT_USER_W-1:0] m_axis_tuser;       // status[2:0]

    int         chk_fails, chk_pending, chk_results, peak_bid, peak_ask;
    logic [4:0] status_seen;

    int tx_idle_pct = 8;
    int rx_idle_pct = 80;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int sent_count  = 0;
    logic [PRICE_W-1:0] px_pool [PX_POOL];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    sorted_price_level_book_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    book_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending),
        .o_results       (chk_results),
        .o_peak_bid      (peak_bid),
        .o_peak_ask      (peak_ask),
        .o_status_seen   (status_seen)
    );

    // Result side: random backpressure, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one update beat, with random idle cycles ahead of it
    task automatic send_update(input logic side, input logic [PRICE_W-1:0] px,
                               input logic [SIZE_W-1:0] qty);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {qty, px};
        s_axis_tuser  <= side;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Pause the sender until every predicted result has been seen
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    function automatic logic [PRICE_W-1:0] pick_price();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return px_pool[$urandom_range(PX_POOL - 1)];
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input int erase_pct);
        if ($urandom_range(99) < erase_pct) return '0;
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Random updates; erase rate swings so the tables both fill and drain
    task automatic run_updates(input int count);
        int k;
        for (k = 0; k < count; k++)
            send_update(1'($urandom_range(1)), pick_price(),
                        pick_size(((k / 100) % 2) ? 55 : 12));
    endtask

    initial begin
        int i;
        // price pool: extremes, a tight cluster around zero, and wide values
        for (i = 0; i < PX_POOL; i++)
            px_pool[i] = (i % 2) ? 64'($urandom_range(400)) - 64'd200 : {$urandom, $urandom};
        px_pool[0] = PX_MIN;
        px_pool[2] = PX_MAX;
        px_pool[4] = '0;
        px_pool[6] = '1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty sides, ordering, updates, erases and extreme values
        send_update(SIDE_ASK, 64'd5, 32'd0);              // erase on empty side
        send_update(SIDE_BID, 64'd100, 32'd10);
        send_update(SIDE_BID, 64'd200, 32'd20);           // new best bid
        send_update(SIDE_BID, 64'd150, 32'd15);           // lands in the middle
        send_update(SIDE_BID, 64'd200, 32'hFFFF_FFF9);    // negative size update
        send_update(SIDE_BID, 64'd150, 32'd0);
        send_update(SIDE_BID, 64'd999, 32'd0);            // erase of absent price
        send_update(SIDE_BID, PX_MAX, 32'h7FFF_FFFF);
        send_update(SIDE_BID, PX_MIN, 32'h8000_0000);
        send_update(SIDE_BID, PX_MIN, 32'd1);
        send_update(SIDE_BID, PX_MAX, 32'd0);
        send_update(SIDE_ASK, PX_MAX, 32'd1);
        send_update(SIDE_ASK, PX_MIN, 32'hFFFF_FFFF);     // new best ask
        send_update(SIDE_ASK, 64'd0, 32'd3);
        send_update(SIDE_ASK, '1, 32'd4);
        send_update(SIDE_ASK, 64'd0, 32'h7FFF_FFFF);
        send_update(SIDE_ASK, PX_MIN, 32'd0);
        send_update(SIDE_ASK, '1, 32'd0);
        send_update(SIDE_ASK, 64'd0, 32'd0);
        send_update(SIDE_ASK, PX_MAX, 32'd0);             // ask side empty again
        send_update(SIDE_BID, 64'd100, 32'd0);
        send_update(SIDE_BID, 64'd200, 32'd0);
        send_update(SIDE_BID, PX_MIN, 32'd0);             // bid side empty again
        send_update(SIDE_BID, PX_MIN, 32'd0);
        wait_drained();

        // slow receiver
        run_updates(300);
        wait_drained();

        // long receiver hold while the sender keeps offering beats
        tx_idle_pct = 0;
        hold_seq++;
        run_updates(40);
        wait_drained();

        // slow sender
        tx_idle_pct = 80;
        rx_idle_pct = 8;
        run_updates(280);
        wait_drained();

        // back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_updates(310);
        wait_drained();
        repeat (TAIL) @(posedge i_clk);

        $display("Run drove %0d book updates and checked %0d results across four flow mixes.",
                 sent_count, chk_results);
        $display("Status codes hit (one bit per code) %b; peak depth bid %0d, ask %0d.",
                 status_seen, peak_bid, peak_ask);
        if (chk_fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/splb_pkg.sv
rtl/splb_side.sv
rtl/splb_dp.sv
rtl/splb_ctrl.sv
rtl/sorted_price_level_book_unit.sv
tb/book_checker.sv
tb/testbench.sv
